### design/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants for the indexed list store
// Sizes, request and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int CAPACITY  = 64;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int MODE_W    = 3;
  localparam int POS_W     = 6;
  localparam int REP_W     = 7;
  localparam int STAT_W    = 2;
  localparam int IN_BITS   = MODE_W + POS_W + DATA_W + REP_W;
  localparam int IN_TDW    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = DATA_W + STAT_W + CNT_W + 1;
  localparam int OUT_TDW   = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_ERASE  = 3'd3,
    MODE_READ   = 3'd4,
    MODE_KEEP   = 3'd5,
    MODE_CLEAR  = 3'd6
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_SHIFT,
    S_INS_DRAIN,
    S_FILL,
    S_ERA_SHIFT,
    S_ERA_DRAIN,
    S_READ_WAIT,
    S_KEEP_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RA_PTR,
    RA_POS,
    RA_LAST
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_PUSH,
    WR_FILL,
    WR_KEEP
  } wr_sel_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_LAST,
    PTR_POS,
    PTR_POS1,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef struct packed {
    logic    load;
    logic    decode;
    rd_sel_t rd_sel;
    logic    shift_ins;
    logic    shift_era;
    ptr_op_t ptr_op;
    wr_sel_t wr_sel;
    logic    held_upd;
    logic    rd_capture;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  st_ok;
    logic  ins_shift;
    logic  n_zero;
    logic  era_shift;
    logic  keep_go;
    logic  ptr_at_pos;
    logic  era_end;
    logic  fill_end;
  } dp_sts_t;

endpackage

### design/ils_datapath.sv
// ----------------------------------------------------------------------------
// ils_datapath: entry memory, pointers and result registers
// One read and one write per cycle; read data is registered.
// ----------------------------------------------------------------------------
module ils_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ils_pkg::IN_TDW-1:0]  in_data,
  input  ils_pkg::dp_cmd_t            cmd,
  output ils_pkg::dp_sts_t            sts,
  output logic [ils_pkg::OUT_TDW-1:0] out_data
);
  import ils_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata;

  mode_t             req_mode;
  logic [POS_W-1:0]  req_pos;
  logic [DATA_W-1:0] req_val;
  logic [REP_W-1:0]  req_n;

  logic [CNT_W-1:0]  held;
  logic [CNT_W-1:0]  held_next;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] ptr_next;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  status_t           status_q;
  status_t           status_c;
  logic [DATA_W-1:0] rd_q;

  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;

  logic [CNT_W-1:0]  pos_ext;
  logic [CNT_W-1:0]  pos_n;
  logic [CNT_W:0]    held_n;
  logic [ADDR_W-1:0] last_idx;

  logic [DATA_W-1:0]   out_rd;
  status_t             out_st;
  logic [CNT_W-1:0]    out_cnt;
  logic                out_empty;

  assign pos_ext  = CNT_W'(req_pos);
  assign pos_n    = pos_ext + CNT_W'(req_n);
  assign held_n   = {1'b0, held} + (CNT_W + 1)'(req_n);
  assign last_idx = ADDR_W'(held - CNT_W'(1));

  // request status
  always_comb begin
    status_c = ST_OK;
    case (req_mode)
      MODE_PUSH:   if (held >= CNT_W'(CAPACITY)) status_c = ST_FULL;
      MODE_POP:    if (held == '0) status_c = ST_EMPTY;
      MODE_INSERT: begin
        if (pos_ext > held) status_c = ST_RANGE;
        else if (held_n > (CNT_W + 1)'(CAPACITY)) status_c = ST_FULL;
      end
      MODE_ERASE, MODE_READ: begin
        if (held == '0) status_c = ST_EMPTY;
        else if (pos_ext >= held) status_c = ST_RANGE;
      end
      default: status_c = ST_OK;
    endcase
  end

  assign sts.mode       = req_mode;
  assign sts.st_ok      = (status_c == ST_OK);
  assign sts.ins_shift  = (held > pos_ext);
  assign sts.n_zero     = (req_n == '0);
  assign sts.era_shift  = ((pos_ext + CNT_W'(1)) < held);
  assign sts.keep_go    = (held > CNT_W'(2));
  assign sts.ptr_at_pos = (ptr == ADDR_W'(req_pos));
  assign sts.era_end    = ((CNT_W'(ptr) + CNT_W'(1)) == held);
  assign sts.fill_end   = ((CNT_W'(ptr) + CNT_W'(1)) == pos_n);

  always_comb begin
    case (cmd.rd_sel)
      RA_POS:  raddr = ADDR_W'(req_pos);
      RA_LAST: raddr = last_idx;
      default: raddr = ptr;
    endcase
  end

  // a pending shift write always wins; the controller never overlaps them
  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = req_val;
    if (pend) begin
      we    = 1'b1;
      waddr = pend_addr;
      wdata = rdata;
    end else begin
      case (cmd.wr_sel)
        WR_PUSH: begin
          we    = 1'b1;
          waddr = ADDR_W'(held);
        end
        WR_FILL: begin
          we    = 1'b1;
          waddr = ptr;
        end
        WR_KEEP: begin
          we    = 1'b1;
          waddr = ADDR_W'(1);
          wdata = rdata;
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    case (cmd.ptr_op)
      PTR_LAST: ptr_next = last_idx;
      PTR_POS:  ptr_next = ADDR_W'(req_pos);
      PTR_POS1: ptr_next = ADDR_W'(req_pos) + ADDR_W'(1);
      PTR_INC:  ptr_next = ptr + ADDR_W'(1);
      PTR_DEC:  ptr_next = ptr - ADDR_W'(1);
      default:  ptr_next = ptr;
    endcase
  end

  always_comb begin
    case (req_mode)
      MODE_PUSH:   held_next = held + CNT_W'(1);
      MODE_POP:    held_next = held - CNT_W'(1);
      MODE_INSERT: held_next = CNT_W'(held_n);
      MODE_ERASE:  held_next = held - CNT_W'(1);
      MODE_KEEP:   held_next = CNT_W'(2);
      MODE_CLEAR:  held_next = '0;
      default:     held_next = held;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      pend <= 1'b0;
    end else begin
      if (cmd.held_upd) begin
        held <= held_next;
      end
      pend <= cmd.shift_ins | cmd.shift_era;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode <= mode_t'(in_data[MODE_W-1:0]);
      req_pos  <= in_data[MODE_W +: POS_W];
      req_val  <= in_data[MODE_W + POS_W +: DATA_W];
      req_n    <= in_data[MODE_W + POS_W + DATA_W +: REP_W];
    end
    ptr <= ptr_next;
    if (cmd.shift_ins) begin
      pend_addr <= ptr + ADDR_W'(req_n);
    end else if (cmd.shift_era) begin
      pend_addr <= ptr - ADDR_W'(1);
    end
    if (cmd.decode) begin
      status_q <= status_c;
      rd_q     <= '0;
    end else if (cmd.rd_capture) begin
      rd_q <= rdata;
    end
    if (cmd.out_load) begin
      out_rd    <= rd_q;
      out_st    <= status_q;
      out_cnt   <= held;
      out_empty <= (held == '0);
    end
  end

  assign out_data = {{(OUT_TDW - OUT_BITS){1'b0}}, out_empty, out_cnt, out_st, out_rd};

endmodule

### design/ils_controller.sv
// ----------------------------------------------------------------------------
// ils_controller: request sequencer for the indexed list store
// Steps shifts, fills and reads; owns both stream handshakes.
// ----------------------------------------------------------------------------
module ils_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ils_pkg::dp_sts_t sts,
  output ils_pkg::dp_cmd_t cmd
);
  import ils_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid & ~out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.rd_sel     = RA_PTR;
    cmd.ptr_op     = PTR_HOLD;
    cmd.wr_sel     = WR_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_DONE;
        if (sts.st_ok) begin
          case (sts.mode)
            MODE_PUSH: begin
              cmd.wr_sel   = WR_PUSH;
              cmd.held_upd = 1'b1;
            end
            MODE_POP, MODE_CLEAR: cmd.held_upd = 1'b1;
            MODE_INSERT: begin
              if (!sts.n_zero) begin
                if (sts.ins_shift) begin
                  cmd.ptr_op = PTR_LAST;
                  state_next = S_INS_SHIFT;
                end else begin
                  cmd.ptr_op = PTR_POS;
                  state_next = S_FILL;
                end
              end
            end
            MODE_ERASE: begin
              if (sts.era_shift) begin
                cmd.ptr_op = PTR_POS1;
                state_next = S_ERA_SHIFT;
              end else begin
                cmd.held_upd = 1'b1;
              end
            end
            MODE_READ: begin
              cmd.rd_sel = RA_POS;
              state_next = S_READ_WAIT;
            end
            MODE_KEEP: begin
              if (sts.keep_go) begin
                cmd.rd_sel = RA_LAST;
                state_next = S_KEEP_WAIT;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      // walk down from the last entry, each word lands n places higher
      S_INS_SHIFT: begin
        cmd.shift_ins = 1'b1;
        if (sts.ptr_at_pos) begin
          state_next = S_INS_DRAIN;
        end else begin
          cmd.ptr_op = PTR_DEC;
        end
      end
      S_INS_DRAIN: begin
        cmd.ptr_op = PTR_POS;
        state_next = S_FILL;
      end
      S_FILL: begin
        cmd.wr_sel = WR_FILL;
        if (sts.fill_end) begin
          cmd.held_upd = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      S_ERA_SHIFT: begin
        cmd.shift_era = 1'b1;
        if (sts.era_end) begin
          state_next = S_ERA_DRAIN;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      S_ERA_DRAIN: begin
        cmd.held_upd = 1'b1;
        state_next   = S_DONE;
      end
      S_READ_WAIT: begin
        cmd.rd_capture = 1'b1;
        state_next     = S_DONE;
      end
      S_KEEP_WAIT: begin
        cmd.wr_sel   = WR_KEEP;
        cmd.held_upd = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### design/indexed_list_store_unit.sv
// A request is loaded in idle and decoded; push, pop, clear, zero-copy insert, rejected
// requests and keep ends on two or fewer entries then go straight to the result. Read and
// keep ends otherwise wait for registered read data; erase shifts the entries above the
// position down (none at the last entry); insert shifts entries up, then writes copies.
// One request in flight; the single write port moves one entry per cycle, so throughput
// is set by the shift and fill length. Reset (rst, synchronous) empties the list.
// ----------------------------------------------------------------------------
// indexed_list_store_unit: fixed-capacity ordered list of data words
// Push, pop, insert copies, erase, read, keep ends and clear on a stream.
// ----------------------------------------------------------------------------
module indexed_list_store_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // mode[2:0], position[8:3], value[40:9], repeat_req[47:41]
  input  logic [ils_pkg::IN_TDW-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // read_data[31:0], status[33:32], entry_count[40:34], is_empty[41], zero pad
  output logic [ils_pkg::OUT_TDW-1:0] m_axis_tdata
);
  import ils_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ils_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ils_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (s_axis_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (m_axis_tdata)
  );

endmodule
